/* rtl/nsrg_pkg.sv */
package nsrg_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HARMONICS_ON  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 3'd5;

  localparam int NOISE_W = 17;
  localparam int AMP_W = 17;
  localparam int DC_W = 18;
  localparam int LEN_W = 17;
  localparam int SAMPLE_W = 16;
  localparam int IN_TDATA_W = 24;

  localparam logic [LEN_W-1:0] LEN_RESET = 17'd1024;
  localparam int MAX_RECORD = 65536;
  localparam int LEN_CAP = (MAX_RECORD < 65536) ? MAX_RECORD : 65536;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  localparam int HARM_COUNT = 5;

  // Sum is kept at 320 * 2^15 per output unit; 320 * 2^15 = 5 * 2^21.
  localparam int TOT_W = 44;
  localparam int UNIT_SHIFT = 21;
  localparam int QUO_W = 18;
  localparam logic [15:0] RECIP5 = 16'd52429;
  localparam int RECIP_SHIFT = 18;
  localparam logic signed [TOT_W-1:0] SUM_HI = 44'sd343586897920;
  localparam logic signed [TOT_W-1:0] SUM_LO = -44'sd343597383680;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic [DC_W-1:0]  dc;
    logic             harm_on;
  } back_cfg_t;

  function automatic logic [14:0] quarter_entry(input int j, input int bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned q;
    longint unsigned one;
    one = 64'd1 << 30;
    x = (longint'(j) * 64'd1686629713) >> (bits - 2);
    x2 = (x * x) >> 30;
    t = one - x2 / 72;
    t = one - ((x2 * t) >> 30) / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    q = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[14:0];
  endfunction

endpackage

/* rtl/noisy_sine_record_generator.sv */
// Noisy sine record generator.
// Input stream: one item per sample tick, in_tdata[16:0] holds a signed noise
// value in 1/32768 full-scale units. Output stream: one item per input item,
// out_tdata is the saturated int16 sample, out_tuser flags saturation and
// out_tlast marks the final sample of each record.
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is always
// high. Write only while the block holds no item in flight.
// Throughput: one item per clock while the queue is not full. The phase
// accumulator and record counter update once per accepted item; the sum and
// the division by the fixed unit scale run in a six-stage back pipeline.
// A four-entry queue sits between front and back; while a result waits with
// out_tready low the whole back pipeline holds, the queue fills, and in_tready
// drops once four items wait in it. Reset clears the phase, the sample counter,
// the queue and all valid flags; registers return to their reset values
// (record length 1024).
module noisy_sine_record_generator #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [nsrg_pkg::IN_TDATA_W-1:0]       in_tdata,  // [16:0] noise_sample
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [nsrg_pkg::SAMPLE_W-1:0]         out_tdata, // [15:0] sample_out
  output logic [0:0]                            out_tuser, // [0] clipped
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nsrg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nsrg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int EW = 5 * SINE_TABLE_BITS + nsrg_pkg::NOISE_W + 1;

  logic [31:0] step_r, offset_r;
  logic [nsrg_pkg::AMP_W-1:0] amp_r;
  logic [nsrg_pkg::DC_W-1:0] dc_r;
  logic harm_r;
  logic [nsrg_pkg::LEN_W-1:0] len_r;
  logic [nsrg_pkg::LEN_W-1:0] eff_len;
  nsrg_pkg::back_cfg_t back_cfg;

  logic push, pop, fifo_full, fifo_valid;
  logic [EW-1:0] push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      offset_r <= '0;
      amp_r <= '0;
      dc_r <= '0;
      harm_r <= 1'b0;
      len_r <= nsrg_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nsrg_pkg::REG_PHASE_STEP:    step_r <= cfg_data;
        nsrg_pkg::REG_PHASE_OFFSET:  offset_r <= cfg_data;
        nsrg_pkg::REG_AMPLITUDE:     amp_r <= cfg_data[nsrg_pkg::AMP_W-1:0];
        nsrg_pkg::REG_DC_OFFSET:     dc_r <= cfg_data[nsrg_pkg::DC_W-1:0];
        nsrg_pkg::REG_HARMONICS_ON:  harm_r <= cfg_data[0];
        nsrg_pkg::REG_RECORD_LENGTH: len_r <= cfg_data[nsrg_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      eff_len = nsrg_pkg::LEN_W'(1);
    end else if (len_r > nsrg_pkg::LEN_W'(nsrg_pkg::LEN_CAP)) begin
      eff_len = nsrg_pkg::LEN_W'(nsrg_pkg::LEN_CAP);
    end else begin
      eff_len = len_r;
    end
  end

  assign back_cfg.amp = amp_r;
  assign back_cfg.dc = dc_r;
  assign back_cfg.harm_on = harm_r;

  nsrg_front #(
    .TB(SINE_TABLE_BITS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .noise(in_tdata[nsrg_pkg::NOISE_W-1:0]),
    .phase_step(step_r),
    .phase_offset(offset_r),
    .eff_len(eff_len),
    .fifo_full(fifo_full),
    .push(push),
    .push_data(push_data)
  );

  nsrg_fifo #(
    .DW(EW)
  ) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_data(push_data),
    .full(fifo_full),
    .pop(pop),
    .not_empty(fifo_valid),
    .pop_data(pop_data)
  );

  nsrg_back #(
    .TB(SINE_TABLE_BITS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(back_cfg),
    .fifo_valid(fifo_valid),
    .fifo_data(pop_data),
    .pop(pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sample_out(out_tdata),
    .clipped(out_tuser[0]),
    .last_of_record(out_tlast)
  );

endmodule

/* rtl/nsrg_fifo.sv */
module nsrg_fifo #(
  parameter int DW = 69
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] mem_r [nsrg_pkg::FIFO_DEPTH];
  logic [nsrg_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [nsrg_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [nsrg_pkg::FIFO_PTR_W:0]   count_r, count_nxt;

  assign full = (count_r == (nsrg_pkg::FIFO_PTR_W+1)'(nsrg_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/nsrg_front.sv */
module nsrg_front #(
  parameter int TB = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [nsrg_pkg::NOISE_W-1:0]        noise,
  input  logic [31:0]                         phase_step,
  input  logic [31:0]                         phase_offset,
  input  logic [nsrg_pkg::LEN_W-1:0]          eff_len,
  input  logic                                fifo_full,
  output logic                                push,
  output logic [5*TB+nsrg_pkg::NOISE_W:0]     push_data
);

  logic [31:0] acc_r, acc_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [16:0] idx_inc;
  logic        last;
  logic [31:0] ph [nsrg_pkg::HARM_COUNT];

  assign in_tready = !fifo_full;
  assign push = in_tvalid && in_tready;

  assign idx_inc = {1'b0, idx_r} + 17'd1;
  assign last = (idx_inc >= eff_len);

  assign ph[0] = acc_r + phase_offset;
  assign ph[1] = (acc_r << 1) + phase_offset;
  assign ph[2] = acc_r + (acc_r << 1) + phase_offset;
  assign ph[3] = (acc_r << 2) + phase_offset;
  assign ph[4] = acc_r + (acc_r << 2) + phase_offset;

  assign push_data = {last, noise, ph[4][31 -: TB], ph[3][31 -: TB], ph[2][31 -: TB],
                      ph[1][31 -: TB], ph[0][31 -: TB]};

  always_comb begin
    acc_nxt = acc_r;
    idx_nxt = idx_r;
    if (push) begin
      if (last) begin
        acc_nxt = '0;
        idx_nxt = '0;
      end else begin
        acc_nxt = acc_r + phase_step;
        idx_nxt = idx_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      idx_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

/* rtl/nsrg_back.sv */
module nsrg_back #(
  parameter int TB = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nsrg_pkg::back_cfg_t               cfg,
  input  logic                              fifo_valid,
  input  logic [5*TB+nsrg_pkg::NOISE_W:0]   fifo_data,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nsrg_pkg::SAMPLE_W-1:0]     sample_out,
  output logic                              clipped,
  output logic                              last_of_record
);

  localparam int QS = 1 << (TB - 2);
  localparam int AW = TB - 1;
  localparam logic [AW-1:0] QS_V = AW'(QS);

  logic [14:0] qw [QS+1];

  for (genvar k = 0; k <= QS; k++) begin : g_tab
    assign qw[k] = nsrg_pkg::quarter_entry(k, TB);
  end

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  logic signed [15:0] s_nxt [nsrg_pkg::HARM_COUNT];
  logic signed [15:0] s_r   [nsrg_pkg::HARM_COUNT];
  logic [nsrg_pkg::NOISE_W-1:0] noise1_r;
  logic last1_r, last2_r, last3_r, last4_r, last5_r;

  for (genvar h = 0; h < nsrg_pkg::HARM_COUNT; h++) begin : g_lane
    logic [TB-1:0] pidx;
    logic [AW-1:0] addr;
    logic signed [15:0] mag;
    assign pidx = fifo_data[h*TB +: TB];
    assign addr = pidx[TB-2] ? QS_V - {1'b0, pidx[TB-3:0]} : {1'b0, pidx[TB-3:0]};
    assign mag = $signed({1'b0, qw[addr]});
    assign s_nxt[h] = pidx[TB-1] ? -mag : mag;
  end

  logic signed [33:0] prod_nxt, prod_r;
  logic signed [18:0] nd;
  logic signed [19:0] harm;
  logic signed [26:0] mid_nxt, mid_r;
  logic signed [nsrg_pkg::TOT_W-1:0] tot_nxt, tot_r;
  logic signed [nsrg_pkg::TOT_W-1:0] mag_tot;
  logic [nsrg_pkg::QUO_W-1:0] q_r;
  logic neg4_r, hi4_r, lo4_r;
  logic [33:0] rec_r;
  logic neg5_r, hi5_r, lo5_r;
  logic [15:0] quo;
  logic [nsrg_pkg::SAMPLE_W-1:0] sample_nxt, sample_r;
  logic clip_r, last_r;

  assign en = !out_valid_r || out_tready;
  assign pop = en && fifo_valid;

  assign prod_nxt = $signed({1'b0, cfg.amp}) * s_r[0];
  assign nd = 19'($signed(noise1_r)) + 19'($signed(cfg.dc));
  assign harm = cfg.harm_on ? (20'(s_r[1]) <<< 3) + (20'(s_r[2]) <<< 2)
                              + (20'(s_r[3]) <<< 1) + 20'(s_r[4]) : 20'sd0;
  assign mid_nxt = (27'(nd) <<< 8) + (27'(nd) <<< 6) + 27'(harm);

  assign tot_nxt = (nsrg_pkg::TOT_W'(prod_r) <<< 8) + (nsrg_pkg::TOT_W'(prod_r) <<< 6)
                   + (nsrg_pkg::TOT_W'(mid_r) <<< 15);
  assign mag_tot = tot_r[nsrg_pkg::TOT_W-1] ? -tot_r : tot_r;

  assign quo = rec_r[nsrg_pkg::RECIP_SHIFT +: 16];

  always_comb begin
    if (hi5_r) begin
      sample_nxt = 16'h7fff;
    end else if (lo5_r) begin
      sample_nxt = 16'h8000;
    end else if (neg5_r) begin
      sample_nxt = -quo;
    end else begin
      sample_nxt = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= fifo_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      noise1_r <= fifo_data[5*TB +: nsrg_pkg::NOISE_W];
      last1_r <= fifo_data[5*TB+nsrg_pkg::NOISE_W];
      prod_r <= prod_nxt;
      mid_r <= mid_nxt;
      last2_r <= last1_r;
      tot_r <= tot_nxt;
      last3_r <= last2_r;
      q_r <= mag_tot[nsrg_pkg::UNIT_SHIFT +: nsrg_pkg::QUO_W];
      neg4_r <= tot_r[nsrg_pkg::TOT_W-1];
      hi4_r <= (tot_r > nsrg_pkg::SUM_HI);
      lo4_r <= (tot_r < nsrg_pkg::SUM_LO);
      last4_r <= last3_r;
      rec_r <= q_r * nsrg_pkg::RECIP5;
      neg5_r <= neg4_r;
      hi5_r <= hi4_r;
      lo5_r <= lo4_r;
      last5_r <= last4_r;
      sample_r <= sample_nxt;
      clip_r <= hi5_r || lo5_r;
      last_r <= last5_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign sample_out = sample_r;
  assign clipped = clip_r;
  assign last_of_record = last_r;

endmodule

/* rtl/nsrg_checker.sv */
module nsrg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 16'h7fff || out_tdata == 16'h8000)
    else $error("clip flag on an unsaturated sample");

endmodule

bind noisy_sine_record_generator nsrg_checker u_nsrg_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser),
  .out_tlast(out_tlast)
);

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_BITS = 10;
  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam longint UNIT_DIV = 64'sd10485760;
  localparam int LEN_LIMIT = 65536;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [nsrg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [nsrg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [nsrg_pkg::SAMPLE_W-1:0] sample;
    logic                          clipped;
    logic                          last;
  } sample_rec_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [nsrg_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [nsrg_pkg::SAMPLE_W-1:0]   out_tdata;
  logic [0:0]                      out_tuser;
  logic                            out_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [nsrg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [nsrg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int quarter_wave [0:QUARTER];

  logic [31:0]                      step_r = '0;
  logic [31:0]                      offset_r = '0;
  logic [nsrg_pkg::AMP_W-1:0]       amp_r = '0;
  logic signed [nsrg_pkg::DC_W-1:0] dc_r = '0;
  logic                             harm_r = 1'b0;
  logic [nsrg_pkg::LEN_W-1:0]       len_r = 17'd1024;
  logic [31:0]                      tone_phase = '0;
  logic [15:0]                      rec_index = '0;

  sample_rec_t expected_samples [$];
  int mismatches = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_cycles = 0;

  noisy_sine_record_generator #(.SINE_TABLE_BITS(TABLE_BITS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // build the quarter-wave Q1.15 table from a 9th order series in Q30
  initial begin : sine_rom
    longint unsigned x, x2, t, s, q;
    longint unsigned one;
    one = 64'd1 << 30;
    for (int j = 0; j <= QUARTER; j++) begin
      x = (longint'(j) * 64'd1686629713) / QUARTER;
      x2 = (x * x) >> 30;
      t = one - x2 / 72;
      t = one - ((x2 * t) >> 30) / 42;
      t = one - ((x2 * t) >> 30) / 20;
      t = one - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      q = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      quarter_wave[j] = int'(q);
    end
  end

  function automatic longint sine_q15(input logic [31:0] ph);
    logic [TABLE_BITS-1:0] idx;
    logic [1:0] quad;
    int j;
    longint v;
    idx = ph[31 -: TABLE_BITS];
    quad = idx[TABLE_BITS-1 -: 2];
    j = int'(idx[TABLE_BITS-3:0]);
    v = quad[0] ? quarter_wave[QUARTER - j] : quarter_wave[j];
    return quad[1] ? -v : v;
  endfunction

  function automatic sample_rec_t predict_sample(
      input logic signed [nsrg_pkg::NOISE_W-1:0] noise);
    longint total, units, amp_l, dc_l, noise_l;
    logic [31:0] ph;
    int eff_len;
    sample_rec_t r;
    amp_l = longint'(amp_r);
    dc_l = longint'(dc_r);
    noise_l = longint'(noise);
    ph = tone_phase + offset_r;
    total = amp_l * sine_q15(ph) * 320;
    total += (noise_l + dc_l) * UNIT_DIV;
    if (harm_r) begin
      for (int hd = 2; hd <= 5; hd++) begin
        ph = hd * tone_phase + offset_r;
        total += sine_q15(ph) * (longint'(32768) << (5 - hd));
      end
    end
    r.clipped = 1'b1;
    if (total > 32767 * UNIT_DIV) begin
      units = 32767;
    end else if (total < -32768 * UNIT_DIV) begin
      units = -32768;
    end else begin
      units = total / UNIT_DIV;
      r.clipped = 1'b0;
    end
    r.sample = units[15:0];
    eff_len = (len_r == 0) ? 1 : ((len_r > LEN_LIMIT) ? LEN_LIMIT : int'(len_r));
    r.last = (int'(rec_index) + 1 >= eff_len);
    if (r.last) begin
      tone_phase = '0;
      rec_index = '0;
    end else begin
      tone_phase = tone_phase + step_r;
      rec_index = rec_index + 16'd1;
    end
    return r;
  endfunction

  task automatic send_item(input logic signed [nsrg_pkg::NOISE_W-1:0] noise);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata <= nsrg_pkg::IN_TDATA_W'($urandom);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {{(nsrg_pkg::IN_TDATA_W-nsrg_pkg::NOISE_W){1'b0}}, noise};
    do @(posedge clk); while (!in_tready);
    expected_samples.push_back(predict_sample(noise));
  endtask

  task automatic write_reg(input logic [nsrg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nsrg_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nsrg_pkg::REG_PHASE_STEP:    step_r = data;
      nsrg_pkg::REG_PHASE_OFFSET:  offset_r = data;
      nsrg_pkg::REG_AMPLITUDE:     amp_r = data[nsrg_pkg::AMP_W-1:0];
      nsrg_pkg::REG_DC_OFFSET:     dc_r = data[nsrg_pkg::DC_W-1:0];
      nsrg_pkg::REG_HARMONICS_ON:  harm_r = data[0];
      nsrg_pkg::REG_RECORD_LENGTH: len_r = data[nsrg_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic signed [nsrg_pkg::NOISE_W-1:0] rand_noise();
    if ($urandom_range(1) == 0) begin
      return nsrg_pkg::NOISE_W'($urandom);
    end
    return nsrg_pkg::NOISE_W'(int'($urandom_range(4000)) - 2000);
  endfunction

  task automatic write_random_settings();
    int v;
    case ($urandom_range(3))
      0: v = 0;
      1: v = 32'hFFFF_FFFF;
      2: v = $urandom_range(32'h00FF_FFFF);
      default: v = $urandom;
    endcase
    write_reg(nsrg_pkg::REG_PHASE_STEP, v);
    case ($urandom_range(2))
      0: v = 0;
      1: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    write_reg(nsrg_pkg::REG_PHASE_OFFSET, v);
    case ($urandom_range(3))
      0: v = 0;
      1: v = 131071;
      2: v = $urandom_range(40000);
      default: v = $urandom_range(131071);
    endcase
    write_reg(nsrg_pkg::REG_AMPLITUDE, v);
    case ($urandom_range(4))
      0: v = -131072;
      1: v = 131071;
      2: v = $urandom;
      default: v = int'($urandom_range(2000)) - 1000;
    endcase
    write_reg(nsrg_pkg::REG_DC_OFFSET, v);
    write_reg(nsrg_pkg::REG_HARMONICS_ON, $urandom);
    case ($urandom_range(9))
      0: v = 0;
      1: v = $urandom_range(131071, 65536);
      2: v = 32'hFFFF_FFFF;
      default: v = $urandom_range(40, 1);
    endcase
    write_reg(nsrg_pkg::REG_RECORD_LENGTH, v);
  endtask

  task automatic test_reset_values();
    send_item(0);
    send_item(65535);
    send_item(-65536);
    send_item(32767);
    send_item(32768);
    send_item(-32768);
    send_item(-32769);
    send_item(-1);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(nsrg_pkg::REG_AMPLITUDE, 131071);
    write_reg(nsrg_pkg::REG_PHASE_STEP, 32'h4000_0000);
    write_reg(nsrg_pkg::REG_PHASE_OFFSET, 32'hFFFF_FFFF);
    write_reg(nsrg_pkg::REG_DC_OFFSET, 131071);
    write_reg(nsrg_pkg::REG_HARMONICS_ON, 1);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 0);
    repeat (3) send_item(0);
    drain();
    write_reg(nsrg_pkg::REG_DC_OFFSET, -131072);
    write_reg(nsrg_pkg::REG_AMPLITUDE, 0);
    write_reg(nsrg_pkg::REG_HARMONICS_ON, 0);
    send_item(-65536);
    send_item(65535);
    drain();
    write_reg(nsrg_pkg::REG_AMPLITUDE, 20000);
    write_reg(nsrg_pkg::REG_DC_OFFSET, 0);
    write_reg(nsrg_pkg::REG_HARMONICS_ON, 1);
    write_reg(nsrg_pkg::REG_PHASE_STEP, 32'h0123_4567);
    write_reg(nsrg_pkg::REG_PHASE_OFFSET, 0);
    repeat (3) send_item(0);
    drain();
  endtask

  task automatic test_record_boundaries();
    write_reg(nsrg_pkg::REG_RECORD_LENGTH, 0);
    repeat (2) send_item(rand_noise());
    drain();
    write_reg(nsrg_pkg::REG_RECORD_LENGTH, 1);
    send_item(rand_noise());
    drain();
    write_reg(nsrg_pkg::REG_RECORD_LENGTH, 1024);
    repeat (4) send_item(rand_noise());
    drain();
    // shorten below the current position: record ends on the next item
    write_reg(nsrg_pkg::REG_RECORD_LENGTH, 3);
    send_item(rand_noise());
    drain();
    write_reg(nsrg_pkg::REG_RECORD_LENGTH, 32'hFFFF_FFFF);
    send_item(rand_noise());
    drain();
  endtask

  task automatic test_random_traffic(input int segments, input bit with_hold);
    int n;
    for (int seg = 0; seg < segments; seg++) begin
      write_random_settings();
      n = $urandom_range(66, 30);
      if (with_hold && seg == 0) begin
        hold_cycles = 400;
      end
      repeat (n) send_item(rand_noise());
      drain();
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_out
    sample_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item: sample %0d clip %0b last %0b",
                   $signed(out_tdata), out_tuser[0], out_tlast);
        end
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want.sample || out_tuser[0] !== want.clipped ||
            out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected sample %0d clip %0b last %0b, got %0d clip %0b last %0b",
                     $signed(want.sample), want.clipped, want.last,
                     $signed(out_tdata), out_tuser[0], out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    tx_idle_pct = 13;
    rx_idle_pct = 50;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_register_extremes();
    test_record_boundaries();
    test_random_traffic(10, 1'b1);
    tx_idle_pct = 50;
    rx_idle_pct = 13;
    test_random_traffic(10, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(10, 1'b0);
    mismatches += expected_samples.size();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/nsrg_pkg.sv
rtl/nsrg_fifo.sv
rtl/nsrg_front.sv
rtl/nsrg_back.sv
rtl/noisy_sine_record_generator.sv
rtl/nsrg_checker.sv
test/tb.sv
